/* rtl/rpn_pkg.sv */
// Shared types, constants and index helpers for the RPN stack calculator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rpn_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EQUALS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 3'd4;

    // Result kinds
    localparam logic RES_TOP = 1'b0;
    localparam logic RES_ERR = 1'b1;

    // Phase counter values
    localparam logic [2:0] PHASE_MAX  = 3'd4;
    localparam logic [2:0] PHASE_OP   = 3'd3;
    localparam logic [2:0] PHASE_SHOW = 3'd1;

    // Q16.16 saturation limits and rounding offset
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [63:0]       Q_HALF = 64'sd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_RD_R,
        S_RD_L,
        S_CAP_L,
        S_MUL,
        S_CALC,
        S_PUSH_RES,
        S_RD_TOP,
        S_EMIT_TOP,
        S_EMIT_ERR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted token
        logic push_num;   // push the latched operand
        logic push_res;   // drop up to two entries, push the result
        logic rd_en;      // read the stack memory
        logic rd_below;   // read one below the top instead of the top
        logic cap_r;      // capture right operand
        logic cap_l;      // capture left operand
        logic mul;        // register the raw product
        logic calc;       // register the saturated result
        logic emit_top;   // load output with the top value
        logic emit_err;   // load output with an error
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a beat
    } dp_status_t;

    // Step a stack slot down, wrapping at zero
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == '0)
            r = IDX_W'(STACK_DEPTH - 1);
        else
            r = idx - IDX_W'(1);
        return r;
    endfunction

    // Step a stack slot up, wrapping at the depth
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(STACK_DEPTH - 1))
            r = '0;
        else
            r = idx + IDX_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/rpn_if.sv */
// Valid/ready channel interfaces for token requests and results.
// Depends on rpn_pkg for field widths.
`default_nettype none

interface rpn_req_if
    import rpn_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        req_type;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface rpn_rsp_if
    import rpn_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic signed [DATA_W-1:0] result_value;

    modport source (output valid, output result_kind, output result_value, input ready);
    modport sink   (input valid, input result_kind, input result_value, output ready);
endinterface

`default_nettype wire

/* rtl/rpn_ctrl.sv */
// Controller state machine: token decode, phase counter, datapath sequencing.
// Depends on rpn_pkg.
`default_nettype none

module rpn_ctrl
    import rpn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [KIND_W-1:0] in_type,
    output logic                   in_ready,
    input  wire dp_status_t        status,
    output ctrl_cmd_t              cmd
);

    state_t     state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] phase_inc;
    logic       accept;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign phase_inc = (phase_reg == PHASE_MAX) ? phase_reg : phase_reg + 3'd1;

    // Hold state and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Update the phase on each accepted token
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (in_type) inside
                KIND_NUMBER:
                    phase_next = phase_inc;
                KIND_ADD, KIND_MUL:
                    phase_next = (phase_inc == PHASE_OP) ? PHASE_SHOW : 3'd0;
                KIND_EQUALS:
                    phase_next = (phase_reg == PHASE_SHOW) ? 3'd0 : phase_reg;
                default:
                    phase_next = 3'd0;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_type) inside
                        KIND_NUMBER:
                            state_next = S_PUSH;
                        KIND_ADD, KIND_MUL:
                            state_next = (phase_inc == PHASE_OP) ? S_RD_R : S_IDLE;
                        KIND_EQUALS:
                            state_next = (phase_reg == PHASE_SHOW) ? S_RD_TOP : S_EMIT_ERR;
                        default:
                            state_next = S_EMIT_ERR;
                    endcase
                end
            end
            S_PUSH:     state_next = S_IDLE;
            S_RD_R:     state_next = S_RD_L;
            S_RD_L:     state_next = S_CAP_L;
            S_CAP_L:    state_next = S_MUL;
            S_MUL:      state_next = S_CALC;
            S_CALC:     state_next = S_PUSH_RES;
            S_PUSH_RES: state_next = S_IDLE;
            S_RD_TOP:   state_next = S_EMIT_TOP;
            S_EMIT_TOP: state_next = status.out_free ? S_IDLE : S_EMIT_TOP;
            S_EMIT_ERR: state_next = status.out_free ? S_IDLE : S_EMIT_ERR;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands per state
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_PUSH:
                cmd.push_num = 1'b1;
            S_RD_R:
                cmd.rd_en = 1'b1;
            S_RD_L:
            begin
                cmd.cap_r    = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_below = 1'b1;
            end
            S_CAP_L:
                cmd.cap_l = 1'b1;
            S_MUL:
                cmd.mul = 1'b1;
            S_CALC:
                cmd.calc = 1'b1;
            S_PUSH_RES:
                cmd.push_res = 1'b1;
            S_RD_TOP:
                cmd.rd_en = 1'b1;
            S_EMIT_TOP:
                cmd.emit_top = status.out_free;
            S_EMIT_ERR:
                cmd.emit_err = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/rpn_dp.sv */
// Datapath: stack memory with top pointer and count, operand registers,
// Q16.16 saturating add and multiply, and the output register. Depends on rpn_pkg.
`default_nettype none

module rpn_dp
    import rpn_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [KIND_W-1:0]        in_type,
    input  wire logic signed [DATA_W-1:0] in_value,
    input  wire ctrl_cmd_t                cmd,
    output dp_status_t                    status,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          out_kind,
    output logic signed [DATA_W-1:0]      out_value
);

    logic [DATA_W-1:0]        mem [STACK_DEPTH];

    logic [IDX_W-1:0]         top_reg, top_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg;

    logic [KIND_W-1:0]        type_reg;
    logic signed [DATA_W-1:0] operand_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic signed [DATA_W-1:0] r_reg, l_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     out_kind_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    logic [IDX_W-1:0]         below;
    logic [IDX_W-1:0]         pop_base;
    logic [IDX_W-1:0]         wr_idx;
    logic [DATA_W-1:0]        wr_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     has_one, has_two;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W-1:0] sum_sat;
    logic signed [63:0]       prod_rnd;
    logic signed [DATA_W-1:0] mul_sat;

    assign below   = idx_dec(top_reg);
    assign has_one = (count_reg != '0);
    assign has_two = (count_reg >= CNT_W'(2));

    // Slot left on top after the operator pops up to two entries
    always_comb
    begin
        if (!has_one)
            pop_base = top_reg;
        else if (!has_two)
            pop_base = below;
        else
            pop_base = idx_dec(below);
    end

    // Push target, data and pointer/count update
    always_comb
    begin
        wr_en      = cmd.push_num || cmd.push_res;
        wr_idx     = cmd.push_res ? idx_inc(pop_base) : idx_inc(top_reg);
        wr_data    = cmd.push_res ? res_reg : operand_reg;
        top_next   = top_reg;
        count_next = count_reg;
        if (cmd.push_num)
        begin
            top_next = wr_idx;
            if (count_reg != CNT_W'(STACK_DEPTH))
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.push_res)
        begin
            top_next   = wr_idx;
            count_next = (has_two ? count_reg - CNT_W'(2) : '0) + CNT_W'(1);
        end
    end

    assign rd_addr = cmd.rd_below ? below : top_reg;

    // Hold pointer, count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            count_reg <= count_next;
            if (cmd.emit_top || cmd.emit_err)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Saturating add
    always_comb
    begin
        sum = {l_reg[DATA_W-1], l_reg} + {r_reg[DATA_W-1], r_reg};
        if (sum[DATA_W] != sum[DATA_W-1])
            sum_sat = sum[DATA_W] ? Q_MIN : Q_MAX;
        else
            sum_sat = sum[DATA_W-1:0];
    end

    // Round product to nearest (ties up), drop 16 fraction bits, saturate
    always_comb
    begin
        prod_rnd = (prod_reg + Q_HALF) >>> 16;
        if (prod_rnd[63:DATA_W-1] == '0 || prod_rnd[63:DATA_W-1] == '1)
            mul_sat = prod_rnd[DATA_W-1:0];
        else
            mul_sat = prod_rnd[63] ? Q_MIN : Q_MAX;
    end

    // Operand, arithmetic and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            type_reg    <= in_type;
            operand_reg <= in_value;
        end
        if (cmd.cap_r)
            r_reg <= has_one ? rd_data_reg : '0;
        if (cmd.cap_l)
            l_reg <= has_two ? rd_data_reg : '0;
        if (cmd.mul)
            prod_reg <= l_reg * r_reg;
        if (cmd.calc)
            res_reg <= (type_reg == KIND_ADD) ? sum_sat : mul_sat;
        if (cmd.emit_top)
        begin
            out_kind_reg  <= RES_TOP;
            out_value_reg <= has_one ? rd_data_reg : '0;
        end
        else if (cmd.emit_err)
        begin
            out_kind_reg  <= RES_ERR;
            out_value_reg <= '0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_value       = out_value_reg;

endmodule

`default_nettype wire

/* rtl/rpn_stack_calculator.sv */
// Reverse-Polish calculator over pre-classified tokens in signed Q16.16.
// A number token is accepted, then pushed. An add or multiply that runs
// reads its two operands through the single stack memory read port, then
// adds or multiplies/rounds, saturates and pushes; one the phase rule rejects
// is dropped without touching the stack. Equals either reads and shows the
// top value or emits an error result, waiting while a result is unclaimed.
// Results sit in an output register, so the next token is taken while a
// result still waits. A full stack overwrites its oldest entry; popping an
// empty stack yields zero. Depends on rpn_pkg, rpn_if, rpn_ctrl and rpn_dp.
`default_nettype none

module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpn_req_if.sink   req,
    rpn_rsp_if.source rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_type  (req.req_type),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rpn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_type   (req.req_type),
        .in_value  (req.operand_value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_kind  (rsp.result_kind),
        .out_value (rsp.result_value)
    );

endmodule

`default_nettype wire
